// ===== rtl/rtnh_pkg.sv =====
// Shared types, constants and helpers of the ray/triangle nearest-hit block.
package rtnh_pkg;

   localparam int COMP_W    = 21;
   localparam int VEC_W     = 63;
   localparam int TILE_W    = 12;
   localparam int MAX_TILES = 4096;
   localparam int MX_W      = 25;
   localparam int MY_W      = 32;
   localparam int PROD_W    = 57;
   localparam int DIV_W     = 64;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ISSUE = 4'b0010,
      S_WAIT  = 4'b0100,
      S_FIN   = 4'b1000
   } state_type;

   localparam logic [4:0] ST_NUM0  = 5'd0;
   localparam logic [4:0] ST_NUM1  = 5'd1;
   localparam logic [4:0] ST_NUM2  = 5'd2;
   localparam logic [4:0] ST_DEN0  = 5'd3;
   localparam logic [4:0] ST_DEN1  = 5'd4;
   localparam logic [4:0] ST_DEN2  = 5'd5;
   localparam logic [4:0] ST_TQ    = 5'd6;
   localparam logic [4:0] ST_P0    = 5'd7;
   localparam logic [4:0] ST_P1    = 5'd8;
   localparam logic [4:0] ST_P2    = 5'd9;
   localparam logic [4:0] ST_BC0   = 5'd10;
   localparam logic [4:0] ST_BC1   = 5'd11;
   localparam logic [4:0] ST_QC0   = 5'd12;
   localparam logic [4:0] ST_QC1   = 5'd13;
   localparam logic [4:0] ST_QB0   = 5'd14;
   localparam logic [4:0] ST_QB1   = 5'd15;
   localparam logic [4:0] ST_UQ    = 5'd16;
   localparam logic [4:0] ST_VQ    = 5'd17;
   localparam logic [4:0] ST_DP0   = 5'd18;
   localparam logic [4:0] ST_DP1   = 5'd19;
   localparam logic [4:0] ST_DP2   = 5'd20;
   localparam logic [4:0] ST_DEPTH = 5'd21;

   localparam logic [1:0] REG_ORIGIN    = 2'd0;
   localparam logic [1:0] REG_DIRECTION = 2'd1;
   localparam logic [1:0] REG_FORWARD   = 2'd2;

   function automatic logic signed [COMP_W-1:0] comp(input logic [VEC_W-1:0] w,
                                                     input logic [1:0] k);
      logic signed [COMP_W-1:0] r;
      unique case (k)
         2'd0:    r = w[20:0];
         2'd1:    r = w[41:21];
         default: r = w[62:42];
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/ray_triangle_nearest_hit.sv =====
// Top level: nearest visible triangle hit along a configured ray.
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/ready   | vertices, normal, visible, tile, last
//  rsp     | out       | rsp_valid/ready   | hit, done, found, nearest tile
//  csr     | in        | psel/penable/...  | origin, direction, forward (8-byte slots)
//
// One item at a time. An invisible tile goes straight to finish. A full hit takes
// 18 passes of the bit-serial multiplier and 4 passes of the bit-serial divider.
// A miss on the plane or projected test ends early.
// Synchronous reset clears configuration, running best and handshake state.
// The result sits in an output register; a stalled rsp holds the next item at finish.
module ray_triangle_nearest_hit
   import rtnh_pkg::*;
#(
   parameter int FRAC_BITS = 10
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [VEC_W-1:0]  req_vertex_a,
   input  logic [VEC_W-1:0]  req_vertex_b,
   input  logic [VEC_W-1:0]  req_vertex_c,
   input  logic [VEC_W-1:0]  req_face_normal,
   input  logic              req_is_visible,
   input  logic [TILE_W-1:0] req_tile_id,
   input  logic              req_last_tile,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_tile_hit,
   output logic              rsp_scan_done,
   output logic              rsp_any_found,
   output logic [TILE_W-1:0] rsp_nearest_tile,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [63:0]       pwdata,
   output logic [63:0]       prdata,
   output logic              pready
);

   localparam logic signed [DIV_W-1:0] ONE_Q     = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [DIV_W-1:0] DEPTH_DIV = 64'sd3 <<< FRAC_BITS;

   state_type state_ff, state_in;
   logic [4:0] step_ff, step_in;

   logic [VEC_W-1:0] origin_ff, origin_in, dir_ff, dir_in, fwd_ff, fwd_in;
   logic [VEC_W-1:0] va_ff, vb_ff, vc_ff, vn_ff;
   logic [TILE_W-1:0] tile_ff;
   logic last_ff;

   logic signed [DIV_W-1:0]  acc_ff, acc_in, num_ff, num_in, bc_ff, bc_in;
   logic signed [DIV_W-1:0]  qc_ff, qc_in, uq_ff, uq_in;
   logic signed [MY_W-1:0]   tq_ff, tq_in;
   logic signed [MX_W-1:0]   p_ff [3];
   logic signed [MX_W-1:0]   p_in [3];
   logic hit_ff, hit_in;
   logic signed [COMP_W-1:0] depth_ff, depth_in;

   logic signed [COMP_W-1:0] best_depth_ff, best_depth_in;
   logic [TILE_W-1:0]        best_index_ff, best_index_in;
   logic                     have_best_ff, have_best_in;

   logic rsp_valid_ff, rsp_valid_in, rsp_hit_ff, rsp_hit_in, rsp_done_ff, rsp_done_in;
   logic rsp_found_ff, rsp_found_in;
   logic [TILE_W-1:0] rsp_tile_ff, rsp_tile_in;

   logic signed [COMP_W-1:0] ca [3], cb [3], cc [3], cn [3], co [3], cd [3], cf [3];
   logic signed [COMP_W:0]   op [3];
   logic signed [COMP_W+1:0] sum3 [3];
   logic [COMP_W-1:0]        an [3];
   logic [1:0] ax, i0, i1, lane;
   logic signed [COMP_W:0] pb0, pb1, pc0, pc1;
   logic signed [MX_W-1:0] q0, q1;

   logic signed [MX_W-1:0]   mx;
   logic signed [MY_W-1:0]   my;
   logic signed [DIV_W-1:0]  dvd, dvs;
   logic is_div, first_op, sub_op;
   logic mul_start, mul_done, div_start, div_done, div_rem_nz, unit_done;
   logic signed [PROD_W-1:0] prod;
   logic signed [DIV_W-1:0]  quo, prod64, acc_sum;

   logic signed [PROD_W-1:0] ptr;
   logic signed [PROD_W:0]   psum;
   logic signed [MX_W-1:0]   pclamp;
   logic signed [MY_W-1:0]   tq_calc;
   logic signed [DIV_W-1:0]  dq;
   logic signed [COMP_W-1:0] depth_calc;
   logic miss_plane, in_tri, visible, qual, cfg_wr;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ca[k]   = comp(va_ff, 2'(k));
         cb[k]   = comp(vb_ff, 2'(k));
         cc[k]   = comp(vc_ff, 2'(k));
         cn[k]   = comp(vn_ff, 2'(k));
         co[k]   = comp(origin_ff, 2'(k));
         cd[k]   = comp(dir_ff, 2'(k));
         cf[k]   = comp(fwd_ff, 2'(k));
         op[k]   = (COMP_W+1)'(co[k]) - (COMP_W+1)'(ca[k]);
         sum3[k] = (COMP_W+2)'(ca[k]) + (COMP_W+2)'(cb[k]) + (COMP_W+2)'(cc[k]);
         an[k]   = cn[k][COMP_W-1] ? COMP_W'(-cn[k]) : COMP_W'(cn[k]);
      end
      ax = 2'd0;
      if (an[1] > an[0]) ax = 2'd1;
      if (an[2] > an[ax]) ax = 2'd2;
      i0 = (ax == 2'd0) ? 2'd1 : 2'd0;
      i1 = (ax == 2'd2) ? 2'd1 : 2'd2;
   end

   assign pb0 = (COMP_W+1)'(cb[i0]) - (COMP_W+1)'(ca[i0]);
   assign pb1 = (COMP_W+1)'(cb[i1]) - (COMP_W+1)'(ca[i1]);
   assign pc0 = (COMP_W+1)'(cc[i0]) - (COMP_W+1)'(ca[i0]);
   assign pc1 = (COMP_W+1)'(cc[i1]) - (COMP_W+1)'(ca[i1]);
   assign q0  = p_ff[i0];
   assign q1  = p_ff[i1];

   always_comb begin
      mx = '0;
      my = '0;
      dvd = '0;
      dvs = '0;
      is_div = 1'b0;
      first_op = 1'b0;
      sub_op = 1'b0;
      unique case (step_ff)
         ST_NUM0, ST_DEN0, ST_P0, ST_DP0: lane = 2'd0;
         ST_NUM1, ST_DEN1, ST_P1, ST_DP1: lane = 2'd1;
         ST_NUM2, ST_DEN2, ST_P2, ST_DP2: lane = 2'd2;
         default:                         lane = 2'd0;
      endcase
      unique case (step_ff)
         ST_NUM0, ST_NUM1, ST_NUM2: begin
            mx = MX_W'(cn[lane]);
            my = MY_W'(op[lane]);
            first_op = (step_ff == ST_NUM0);
         end
         ST_DEN0, ST_DEN1, ST_DEN2: begin
            mx = MX_W'(cn[lane]);
            my = MY_W'(cd[lane]);
            first_op = (step_ff == ST_DEN0);
            sub_op = 1'b1;
         end
         ST_TQ: begin
            is_div = 1'b1;
            dvd = num_ff <<< FRAC_BITS;
            dvs = acc_ff;
         end
         ST_P0, ST_P1, ST_P2: begin
            mx = MX_W'(cd[lane]);
            my = tq_ff;
            first_op = 1'b1;
         end
         ST_BC0: begin
            mx = MX_W'(pb0);
            my = MY_W'(pc1);
            first_op = 1'b1;
         end
         ST_BC1: begin
            mx = MX_W'(pb1);
            my = MY_W'(pc0);
            sub_op = 1'b1;
         end
         ST_QC0: begin
            mx = q0;
            my = MY_W'(pc1);
            first_op = 1'b1;
         end
         ST_QC1: begin
            mx = q1;
            my = MY_W'(pc0);
            sub_op = 1'b1;
         end
         ST_QB0: begin
            mx = q0;
            my = MY_W'(pb1);
            first_op = 1'b1;
         end
         ST_QB1: begin
            mx = q1;
            my = MY_W'(pb0);
            sub_op = 1'b1;
         end
         ST_UQ: begin
            is_div = 1'b1;
            dvd = qc_ff <<< FRAC_BITS;
            dvs = bc_ff;
         end
         ST_VQ: begin
            is_div = 1'b1;
            dvd = acc_ff <<< FRAC_BITS;
            dvs = -bc_ff;
         end
         ST_DP0, ST_DP1, ST_DP2: begin
            mx = MX_W'(sum3[lane]);
            my = MY_W'(cf[lane]);
            first_op = (step_ff == ST_DP0);
         end
         ST_DEPTH: begin
            is_div = 1'b1;
            dvd = acc_ff;
            dvs = DEPTH_DIV;
         end
         default: begin
         end
      endcase
   end

   assign mul_start = (state_ff == S_ISSUE) && !is_div;
   assign div_start = (state_ff == S_ISSUE) && is_div;
   assign unit_done = is_div ? div_done : mul_done;

   rtnh_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .x     (mx),
      .y     (my),
      .done  (mul_done),
      .prod  (prod)
   );

   rtnh_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .dvd    (dvd),
      .dvs    (dvs),
      .done   (div_done),
      .quo    (quo),
      .rem_nz (div_rem_nz)
   );

   assign prod64  = DIV_W'(prod);
   assign acc_sum = (first_op ? '0 : acc_ff) + (sub_op ? -prod64 : prod64);

   assign miss_plane = (acc_sum == '0) || (num_ff == '0) ||
                       (num_ff[DIV_W-1] != acc_sum[DIV_W-1]);

   assign ptr = (prod >>> FRAC_BITS) +
                ((prod[PROD_W-1] && (prod[FRAC_BITS-1:0] != '0)) ? 57'sd1 : 57'sd0);
   assign psum = (PROD_W+1)'(op[lane]) + (PROD_W+1)'(ptr);
   assign pclamp = (psum > 58'sd8388608)  ? 25'sd8388608 :
                   (psum < -58'sd8388608) ? -25'sd8388608 : MX_W'(psum);

   assign tq_calc = (quo > 64'sd2147483647) ? 32'sd2147483647 : MY_W'(quo);

   assign in_tri = !uq_ff[DIV_W-1] && !quo[DIV_W-1] && ((uq_ff + quo) <= ONE_Q);

   assign dq = quo - ((div_rem_nz && acc_ff[DIV_W-1]) ? 64'sd1 : 64'sd0);
   assign depth_calc = (dq > 64'sd1048575)  ? 21'sd1048575 :
                       (dq < -64'sd1048576) ? -21'sd1048576 : COMP_W'(dq);

   assign visible = req_is_visible && ((TILE_W+5)'(req_tile_id) < (TILE_W+5)'(MAX_TILES));
   assign qual    = hit_ff && (depth_ff < best_depth_ff);
   assign cfg_wr  = psel && penable && pwrite && pready;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      origin_in = origin_ff;
      dir_in = dir_ff;
      fwd_in = fwd_ff;
      acc_in = acc_ff;
      num_in = num_ff;
      bc_in = bc_ff;
      qc_in = qc_ff;
      uq_in = uq_ff;
      tq_in = tq_ff;
      p_in = p_ff;
      hit_in = hit_ff;
      depth_in = depth_ff;
      best_depth_in = best_depth_ff;
      best_index_in = best_index_ff;
      have_best_in = have_best_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hit_in = rsp_hit_ff;
      rsp_done_in = rsp_done_ff;
      rsp_found_in = rsp_found_ff;
      rsp_tile_in = rsp_tile_ff;

      if (cfg_wr) begin
         unique case (paddr[4:3])
            REG_ORIGIN:    origin_in = pwdata[VEC_W-1:0];
            REG_DIRECTION: dir_in = pwdata[VEC_W-1:0];
            REG_FORWARD:   fwd_in = pwdata[VEC_W-1:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               hit_in = 1'b0;
               step_in = ST_NUM0;
               state_in = visible ? S_ISSUE : S_FIN;
            end
         end
         S_ISSUE: state_in = S_WAIT;
         S_WAIT: begin
            if (unit_done) begin
               step_in = step_ff + 5'd1;
               state_in = S_ISSUE;
               if (!is_div) acc_in = acc_sum;
               unique case (step_ff)
                  ST_NUM2: num_in = acc_sum;
                  ST_DEN2: if (miss_plane) state_in = S_FIN;
                  ST_TQ:   tq_in = tq_calc;
                  ST_P0, ST_P1, ST_P2: p_in[lane] = pclamp;
                  ST_BC1: begin
                     bc_in = acc_sum;
                     if (acc_sum == '0) state_in = S_FIN;
                  end
                  ST_QC1:  qc_in = acc_sum;
                  ST_UQ:   uq_in = quo;
                  ST_VQ:   if (!in_tri) state_in = S_FIN;
                  ST_DEPTH: begin
                     depth_in = depth_calc;
                     hit_in = 1'b1;
                     state_in = S_FIN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in = hit_ff;
               rsp_done_in = last_ff;
               rsp_found_in = have_best_ff || qual;
               rsp_tile_in = qual ? tile_ff : (have_best_ff ? best_index_ff : '0);
               if (last_ff) begin
                  best_depth_in = '0;
                  best_index_in = '0;
                  have_best_in = 1'b0;
               end else if (qual) begin
                  best_depth_in = depth_ff;
                  best_index_in = tile_ff;
                  have_best_in = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= ST_NUM0;
         origin_ff <= '0;
         dir_ff <= '0;
         fwd_ff <= '0;
         best_depth_ff <= '0;
         best_index_ff <= '0;
         have_best_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         origin_ff <= origin_in;
         dir_ff <= dir_in;
         fwd_ff <= fwd_in;
         best_depth_ff <= best_depth_in;
         best_index_ff <= best_index_in;
         have_best_ff <= have_best_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff <= hit_in;
      end
      if (req_valid && req_ready) begin
         va_ff <= req_vertex_a;
         vb_ff <= req_vertex_b;
         vc_ff <= req_vertex_c;
         vn_ff <= req_face_normal;
         tile_ff <= req_tile_id;
         last_ff <= req_last_tile;
      end
      acc_ff <= acc_in;
      num_ff <= num_in;
      bc_ff <= bc_in;
      qc_ff <= qc_in;
      uq_ff <= uq_in;
      tq_ff <= tq_in;
      p_ff <= p_in;
      depth_ff <= depth_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_done_ff <= rsp_done_in;
      rsp_found_ff <= rsp_found_in;
      rsp_tile_ff <= rsp_tile_in;
   end

   always_comb begin
      unique case (paddr[4:3])
         REG_ORIGIN:    prdata = {1'b0, origin_ff};
         REG_DIRECTION: prdata = {1'b0, dir_ff};
         REG_FORWARD:   prdata = {1'b0, fwd_ff};
         default:       prdata = '0;
      endcase
   end

   assign pready           = 1'b1;
   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tile_hit     = rsp_hit_ff;
   assign rsp_scan_done    = rsp_done_ff;
   assign rsp_any_found    = rsp_found_ff;
   assign rsp_nearest_tile = rsp_tile_ff;

endmodule

// ===== rtl/rtnh_mul.sv =====
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
module rtnh_mul
   import rtnh_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [MX_W-1:0]   x,
   input  logic signed [MY_W-1:0]   y,
   output logic                     done,
   output logic signed [PROD_W-1:0] prod
);

   localparam int CNT_W = $clog2(MY_W);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [PROD_W-1:0] mcand_ff, mcand_in;
   logic [MY_W-1:0]          mplier_ff, mplier_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     last_bit;

   assign last_bit = (cnt_ff == CNT_W'(MY_W-1));

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         mcand_in  = PROD_W'(x);
         mplier_in = y;
         prod_in   = '0;
      end else if (busy_ff) begin
         // top multiplier bit carries negative weight
         if (mplier_ff[0]) begin
            prod_in = last_bit ? (prod_ff - mcand_ff) : (prod_ff + mcand_ff);
         end
         mcand_in  = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + CNT_W'(1);
         if (last_bit) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

// ===== rtl/rtnh_div.sv =====
// Bit-serial restoring signed divider, truncating quotient, one bit per cycle.
module rtnh_div
   import rtnh_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [DIV_W-1:0] dvd,
   input  logic signed [DIV_W-1:0] dvs,
   output logic                    done,
   output logic signed [DIV_W-1:0] quo,
   output logic                    rem_nz
);

   localparam int CNT_W = $clog2(DIV_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W:0]   rem_ff, rem_in;
   logic [DIV_W-1:0] q_ff, q_in;
   logic [DIV_W-1:0] d_ff, d_in;
   logic             neg_ff, neg_in;
   logic [DIV_W:0]   shifted, trial;

   assign shifted = {rem_ff[DIV_W-1:0], q_ff[DIV_W-1]};
   assign trial   = shifted - {1'b0, d_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         q_in    = dvd[DIV_W-1] ? DIV_W'(-dvd) : DIV_W'(dvd);
         d_in    = dvs[DIV_W-1] ? DIV_W'(-dvs) : DIV_W'(dvs);
         neg_in  = dvd[DIV_W-1] ^ dvs[DIV_W-1];
      end else if (busy_ff) begin
         if (!trial[DIV_W]) begin
            rem_in = trial;
            q_in   = {q_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            q_in   = {q_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIV_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
   end

   assign done   = done_ff;
   assign quo    = neg_ff ? -$signed(q_ff) : $signed(q_ff);
   assign rem_nz = |rem_ff;

endmodule

// ===== rtl/rtnh_checker.sv =====
// Port-level checker for the nearest-hit block, bound to the top level.
module rtnh_checker
   import rtnh_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [VEC_W-1:0]  req_vertex_a,
   input logic [VEC_W-1:0]  req_vertex_b,
   input logic [VEC_W-1:0]  req_vertex_c,
   input logic [VEC_W-1:0]  req_face_normal,
   input logic              req_is_visible,
   input logic [TILE_W-1:0] req_tile_id,
   input logic              req_last_tile,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_tile_hit,
   input logic              rsp_scan_done,
   input logic              rsp_any_found,
   input logic [TILE_W-1:0] rsp_nearest_tile,
   input logic              psel,
   input logic              penable,
   input logic              pwrite,
   input logic [4:0]        paddr,
   input logic [63:0]       pwdata,
   input logic [63:0]       prdata,
   input logic              pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tile_hit) &&
      $stable(rsp_scan_done) && $stable(rsp_any_found) && $stable(rsp_nearest_tile))
      else $error("rsp item changed while stalled");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in work");

   a_no_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_any_found |-> rsp_nearest_tile == '0)
      else $error("nearest tile nonzero without a find");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind ray_triangle_nearest_hit rtnh_checker u_rtnh_checker (.*);
